[rtl/core/lss_pkg.sv]
package lss_pkg;

  // Request codes carried in the action field.
  localparam logic [2:0] ACT_PUSH    = 3'd0;
  localparam logic [2:0] ACT_POP     = 3'd1;
  localparam logic [2:0] ACT_PEEK    = 3'd2;
  localparam logic [2:0] ACT_SEARCH  = 3'd3;
  localparam logic [2:0] ACT_DISPLAY = 3'd4;
  localparam logic [2:0] ACT_CLEAR   = 3'd5;

  // Status codes returned with every result word.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Field widths of the request and result words.
  localparam int unsigned ActionW = 3;
  localparam int unsigned WordW   = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 6;
  localparam int unsigned CapW    = 6;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PEEK,
    S_SCAN,
    S_DISP
  } state_t;

endpackage

[rtl/core/lifo_stack_with_search.sv]
// Bounded LIFO stack of signed 32-bit words with search and display. A request word
// on the slave side (action in tuser, operand in tdata) is taken only while the
// sequencer is idle and the result register is free or being emptied. Push, clear,
// unused codes and every request that fails at once (overflow, empty stack) are answered from idle.
// Pop and peek pass through a read state, as the stack memory has one registered read port.
// Search compares one stored word per cycle from the top down; display sends one word
// per cycle from top to bottom while the master side does not stall, and marks the
// bottom word with tlast. The capacity register limits the fill to min(capacity, DEPTH);
// lowering it below the fill discards nothing. The stored words are not cleared at reset.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // Capacity register write.
  input  logic                          capacity_we,
  input  logic [lss_pkg::CapW-1:0]      capacity_wdata,
  // Request side.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lss_pkg::WordW-1:0]     s_tdata,   // [31:0] operand
  input  logic [lss_pkg::ActionW-1:0]   s_tuser,   // [2:0] action
  // Result side.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lss_pkg::OutDataW-1:0]  m_tdata,   // [31:0] data, [37:32] position,
                                                   // [39:38] status, [45:40] count
  output logic                          m_tlast    // last
);
  import lss_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW = 7;

  state_t state, state_next;

  logic [CapW-1:0]  capacity;
  logic [CW-1:0]    fill, fill_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic [WordW-1:0] key;
  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rd_data;

  logic             accept;
  logic             out_free;
  logic             full;
  logic             empty;
  logic             hit;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic             emit;
  logic [WordW-1:0] emit_data;
  logic [PosW-1:0]  emit_pos;
  logic [StatusW-1:0] emit_status;
  logic             emit_last;

  // Handshake and simple conditions.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign empty    = (fill == '0);
  assign full     = (CmpW'(fill) >= CmpW'(capacity)) || (fill == CW'(DEPTH));
  assign hit      = (rd_data == key);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !empty) begin
          case (s_tuser)
            ACT_POP:     state_next = S_POP;
            ACT_PEEK:    state_next = S_PEEK;
            ACT_SEARCH:  state_next = S_SCAN;
            ACT_DISPLAY: state_next = S_DISP;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_POP, S_PEEK: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if ((hit || ptr == CW'(1)) && out_free) state_next = S_IDLE;
      end
      S_DISP: begin
        if (out_free && ptr == CW'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath control: memory access, fill and pointer updates, result word.
  always_comb begin
    fill_next   = fill;
    ptr_next    = ptr;
    rd_en       = 1'b0;
    rd_addr     = AW'(fill - CW'(1));
    wr_en       = 1'b0;
    emit        = 1'b0;
    emit_data   = '0;
    emit_pos    = '0;
    emit_status = ST_OK;
    emit_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            ACT_PUSH: begin
              emit = 1'b1;
              if (full) begin
                emit_status = ST_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                fill_next = fill + CW'(1);
              end
            end
            ACT_POP, ACT_PEEK, ACT_DISPLAY: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                rd_en    = 1'b1;
                ptr_next = fill;
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_NOTFOUND;
              end else begin
                rd_en    = 1'b1;
                ptr_next = fill;
              end
            end
            ACT_CLEAR: begin
              emit      = 1'b1;
              fill_next = '0;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rd_data;
          fill_next = fill - CW'(1);
        end
      end
      S_PEEK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rd_data;
        end
      end
      S_SCAN: begin
        rd_addr = AW'(ptr - CW'(2));
        if (hit) begin
          emit     = out_free;
          emit_pos = PosW'(ptr);
        end else if (ptr == CW'(1)) begin
          emit        = out_free;
          emit_status = ST_NOTFOUND;
        end else begin
          rd_en    = 1'b1;
          ptr_next = ptr - CW'(1);
        end
      end
      S_DISP: begin
        rd_addr = AW'(ptr - CW'(2));
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rd_data;
          emit_last = (ptr == CW'(1));
          if (ptr != CW'(1)) begin
            rd_en    = 1'b1;
            ptr_next = ptr - CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers and capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      ptr      <= '0;
      capacity <= CapW'(32);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      ptr   <= ptr_next;
      if (capacity_we) capacity <= capacity_wdata;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Search key and result word.
  always_ff @(posedge clk) begin
    if (accept) key <= s_tdata;
    if (emit) begin
      m_tdata <= {2'b00, CountW'(fill_next), emit_status, emit_pos, emit_data};
      m_tlast <= emit_last;
    end
  end

  // Stack memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(fill)] <= s_tdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // The fill never exceeds the built depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("stack fill above depth");

  // A successful push grows the fill by exactly one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == ACT_PUSH && !full) |=> fill == $past(fill) + CW'(1))
    else $error("push did not grow the fill");

  // While walking the stack the pointer stays within the stored entries.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DISP) |-> (ptr != '0 && ptr <= fill))
    else $error("walk pointer out of range");

  // A result word without tlast is only ever part of a display still running.
  a_notlast_disp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> state == S_DISP)
    else $error("non-final result outside display");

endmodule

[tb/sv/lifo_stack_with_search_chk.sv]
// Watches both streams of the stack and works out the result words that each
// accepted request ought to produce. Each result word from the DUT is then
// compared with the oldest result still outstanding.
module lifo_stack_with_search_chk #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          capacity_we,
  input  logic [lss_pkg::CapW-1:0]      capacity_wdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [lss_pkg::WordW-1:0]     s_tdata,   // [31:0] operand
  input  logic [lss_pkg::ActionW-1:0]   s_tuser,   // [2:0] action
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [lss_pkg::OutDataW-1:0]  m_tdata,   // [31:0] data, [37:32] position,
                                                   // [39:38] status, [45:40] count
  input  logic                          m_tlast,   // last
  output int                            fail_count,
  output int                            pending,
  output int                            words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  typedef struct packed {
    logic [WordW-1:0]   data;
    logic [PosW-1:0]    position;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic               last;
  } result_t;

  // Shadow copy of the stack, its fill and the capacity register.
  logic [WordW-1:0]  stack_words [DEPTH];
  logic [CountW-1:0] fill;
  logic [CapW-1:0]   cap_reg;
  result_t           outstanding [$];

  // Queues one result word; the count field always carries the fill after the request.
  task automatic note(input logic [WordW-1:0] data, input logic [PosW-1:0] position,
                      input logic [StatusW-1:0] status, input logic last);
    outstanding.push_back({data, position, status, fill, last});
  endtask

  // Applies one request to the shadow stack and queues the words it causes.
  task automatic stack_request(input logic [ActionW-1:0] act, input logic [WordW-1:0] opnd);
    int unsigned limit;
    int unsigned idx;
    limit = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    case (act)
      ACT_PUSH: begin
        if (fill >= limit) begin
          note('0, '0, ST_OVERFLOW, 1'b1);
        end else begin
          stack_words[fill] = opnd;
          fill = fill + 1'b1;
          note('0, '0, ST_OK, 1'b1);
        end
      end
      ACT_POP: begin
        if (fill == 0) begin
          note('0, '0, ST_EMPTY, 1'b1);
        end else begin
          fill = fill - 1'b1;
          note(stack_words[fill], '0, ST_OK, 1'b1);
        end
      end
      ACT_PEEK: begin
        if (fill == 0) note('0, '0, ST_EMPTY, 1'b1);
        else note(stack_words[fill - 1'b1], '0, ST_OK, 1'b1);
      end
      ACT_SEARCH: begin
        // Topmost match wins, reported as its position counted from the bottom.
        idx = fill;
        while (idx > 0 && stack_words[idx - 1] != opnd) idx--;
        if (idx == 0) note('0, '0, ST_NOTFOUND, 1'b1);
        else note('0, PosW'(idx), ST_OK, 1'b1);
      end
      ACT_DISPLAY: begin
        if (fill == 0) begin
          note('0, '0, ST_EMPTY, 1'b1);
        end else begin
          for (idx = fill; idx > 0; idx--) note(stack_words[idx - 1], '0, ST_OK, idx == 1);
        end
      end
      ACT_CLEAR: begin
        // The stored words stay in place; only the fill drops to zero.
        fill = '0;
        note('0, '0, ST_OK, 1'b1);
      end
      default: begin
        note('0, '0, ST_OK, 1'b1);
      end
    endcase
  endtask

  // Results are compared before a request taken at the same edge is applied.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      fill = '0;
      cap_reg = CapW'(32);
      outstanding.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[37:32], m_tdata[39:38], m_tdata[45:40], m_tlast};
        words_checked++;
        if (outstanding.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result word: data %h pos %0d status %0d count %0d last %b",
                     $realtime, got.data, got.position, got.status, got.count, got.last);
        end else begin
          want = outstanding.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected data %h pos %0d status %0d count %0d last %b",
                       want.data, want.position, want.status, want.count, want.last);
              $display("  actual   data %h pos %0d status %0d count %0d last %b",
                       got.data, got.position, got.status, got.count, got.last);
            end
          end
        end
      end
      if (capacity_we) cap_reg = capacity_wdata;
      if (s_tvalid && s_tready) stack_request(s_tuser, s_tdata);
    end
    pending = outstanding.size();
  end

endmodule

[tb/sv/lifo_stack_with_search_tb.sv]
module lifo_stack_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  localparam int unsigned DEPTH = 32;

  // Action codes that the block does not define.
  localparam logic [ActionW-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ActionW-1:0] ACT_SPARE_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 capacity_we = 1'b0;
  logic [CapW-1:0]      capacity_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [WordW-1:0]     s_tdata = '0;
  logic [ActionW-1:0]   s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic                 m_tlast;

  int fail_count;
  int pending;
  int words_checked;

  bit calm = 1'b0;
  bit s_took = 1'b0;
  int requests = 0;
  int settings = 0;
  logic [WordW-1:0] pushed_pool [8] = '{default: '0};
  int pool_next = 0;

  always #2 clk = ~clk;

  lifo_stack_with_search #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
  );

  lifo_stack_with_search_chk #(
    .DEPTH(DEPTH)
  ) u_chk (
    .clk            (clk),
    .rst            (rst),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_checked  (words_checked)
  );

  // Registers the request handshake so that the driver sees it at the falling edge.
  always @(posedge clk) s_took <= s_tvalid && s_tready;

  // The result side stalls about a third of the time, except in the calm stretch.
  always @(negedge clk) m_tready <= calm || ($urandom_range(99) >= 32);

  // Mostly awkward words: the extremes, small values that repeat, and random ones.
  function automatic logic [WordW-1:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3, 4, 5: return WordW'($urandom_range(7));
      default: return $urandom();
    endcase
  endfunction

  // Offers one request word, with random gaps before it, and returns once it is taken.
  task automatic send_request(input logic [ActionW-1:0] act, input logic [WordW-1:0] opnd);
    while (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= opnd;
    do @(negedge clk); while (!s_took);
    requests++;
    if (act == ACT_PUSH) begin
      pushed_pool[pool_next] = opnd;
      pool_next = (pool_next + 1) % 8;
    end
  endtask

  // Draws a request; searches often look for a word that was pushed recently.
  task automatic random_request(input int push_pct);
    int roll;
    logic [ActionW-1:0] act;
    logic [WordW-1:0] opnd;
    opnd = pick_operand();
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      act = ACT_PUSH;
    end else begin
      roll = $urandom_range(99);
      if (roll < 30) act = ACT_POP;
      else if (roll < 45) act = ACT_PEEK;
      else if (roll < 75) begin
        act = ACT_SEARCH;
        if ($urandom_range(1)) opnd = pushed_pool[$urandom_range(7)];
      end
      else if (roll < 88) act = ACT_DISPLAY;
      else if (roll < 96) act = ACT_CLEAR;
      else act = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
    end
    send_request(act, opnd);
  endtask

  // Stops offering requests and waits until every result word has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] cap);
    drain_results();
    capacity_we    <= 1'b1;
    capacity_wdata <= cap;
    @(negedge clk);
    capacity_we <= 1'b0;
    settings++;
  endtask

  // Hard limit on the whole run.
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int caps [7] = '{32, 5, 1, 63, 17, 3, 32};
    int push_bias [7] = '{50, 45, 40, 60, 50, 45, 35};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every reading request against an empty stack.
    send_request(ACT_POP, '0);
    send_request(ACT_PEEK, '0);
    send_request(ACT_SEARCH, '0);
    send_request(ACT_DISPLAY, '0);

    // Extreme words and a repeated zero, so that search must find the topmost copy.
    send_request(ACT_PUSH, 32'h7FFF_FFFF);
    send_request(ACT_PUSH, 32'h8000_0000);
    send_request(ACT_PUSH, 32'h0000_0000);
    send_request(ACT_PUSH, 32'hFFFF_FFFF);
    send_request(ACT_PUSH, 32'h0000_0000);
    send_request(ACT_PEEK, '0);
    send_request(ACT_SEARCH, 32'h0000_0000);
    send_request(ACT_SEARCH, 32'h8000_0000);
    send_request(ACT_SEARCH, 32'h1234_5678);
    send_request(ACT_DISPLAY, '0);
    send_request(ACT_POP, '0);
    send_request(ACT_SPARE_LO, 32'hFFFF_FFFF);
    send_request(ACT_SPARE_HI, 32'h5A5A_5A5A);
    send_request(ACT_CLEAR, '0);
    send_request(ACT_POP, '0);

    // A capacity of zero refuses every push.
    set_capacity(6'd0);
    send_request(ACT_PUSH, 32'h0000_0001);

    // Capacity lowered below the fill: nothing is lost, pushes fail until pops make room.
    set_capacity(6'd2);
    send_request(ACT_PUSH, 32'h0000_0011);
    send_request(ACT_PUSH, 32'h0000_0022);
    send_request(ACT_PUSH, 32'h0000_0033);
    set_capacity(6'd1);
    send_request(ACT_PUSH, 32'h0000_0044);
    send_request(ACT_POP, '0);
    send_request(ACT_PUSH, 32'h0000_0055);
    send_request(ACT_POP, '0);
    send_request(ACT_PUSH, 32'h0000_0066);
    send_request(ACT_CLEAR, '0);

    // A capacity above the depth acts as the depth: fill it, overflow, list it all.
    set_capacity(6'd63);
    repeat (DEPTH + 1) send_request(ACT_PUSH, pick_operand());
    send_request(ACT_DISPLAY, '0);
    send_request(ACT_SEARCH, pushed_pool[$urandom_range(7)]);
    send_request(ACT_CLEAR, '0);

    // Random phases under several capacities; one of them runs with no idling at all.
    for (int p = 0; p < 7; p++) begin
      set_capacity(CapW'(caps[p]));
      calm = (p == 4);
      repeat (28) random_request(push_bias[p]);
    end
    calm = 1'b0;

    drain_results();
    $display("Sent %0d requests under %0d capacity settings; %0d result words compared.",
             requests, settings, words_checked);
    $display("Covered empty, full, overflow, lowered capacity, search, display and spare codes.");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lss_pkg.sv
rtl/core/lifo_stack_with_search.sv
tb/sv/lifo_stack_with_search_chk.sv
tb/sv/lifo_stack_with_search_tb.sv
